@@ sv/brsc_pkg.sv @@
// Shared types and constants for the byte range to sector command splitter.
// No dependencies; every other file refers to this package by scoped names.
package brsc_pkg;

   // Command action codes.
   localparam logic [2:0] ACT_RD_SCRATCH = 3'd0;
   localparam logic [2:0] ACT_WR_SCRATCH = 3'd1;
   localparam logic [2:0] ACT_RD_RUN     = 3'd2;
   localparam logic [2:0] ACT_WR_RUN     = 3'd3;
   localparam logic [2:0] ACT_STATUS     = 3'd4;

   // Status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_INVALID   = 2'd1;
   localparam logic [1:0] ST_READ_ONLY = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_SECTOR_SIZE  = 2'd0;
   localparam logic [1:0] CSR_SECTOR_TOTAL = 2'd1;
   localparam logic [1:0] CSR_READ_ONLY    = 2'd2;

   // Widths of the divider operands.
   localparam int DIV_W = 42;
   localparam int SS_W  = 13;

   // Plan of one request, handed from the front to the back.
   typedef struct packed {
      logic [1:0]      status;
      logic            wr;
      logic            head;
      logic            head_only;
      logic            run;
      logic            tail;
      logic [31:0]     first;
      logic [31:0]     lastsec;
      logic [31:0]     run_sec;
      logic [31:0]     run_cnt;
      logic [31:0]     run_boff;
      logic [31:0]     tail_boff;
      logic [SS_W-1:0] skip;
      logic [SS_W-1:0] head_n;
      logic [SS_W-1:0] tail_bytes;
   } desc_type;

endpackage

@@ sv/brsc_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on brsc_pkg for the operand widths.
module brsc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [brsc_pkg::DIV_W-1:0]  dividend,
   input  logic [brsc_pkg::SS_W-1:0]   divisor,
   output logic                        done,
   output logic [brsc_pkg::DIV_W-1:0]  quotient,
   output logic [brsc_pkg::SS_W-1:0]   remainder
);

   logic [5:0]                    count_ff, count_in;
   logic                          done_ff, done_in;
   logic [brsc_pkg::DIV_W-1:0]    quo_ff, quo_in;
   logic [brsc_pkg::SS_W-1:0]     rem_ff, rem_in;
   logic [brsc_pkg::SS_W:0]       trial;

   // One shift and trial subtraction per cycle.
   always_comb begin
      trial    = {rem_ff, quo_ff[brsc_pkg::DIV_W-1]};
      count_in = count_ff;
      done_in  = 1'b0;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (go) begin
         count_in = 6'(brsc_pkg::DIV_W);
         quo_in   = dividend;
         rem_in   = '0;
      end else if (count_ff != 6'd0) begin
         count_in = count_ff - 6'd1;
         done_in  = (count_ff == 6'd1);
         if (trial >= {1'b0, divisor}) begin
            rem_in = brsc_pkg::SS_W'(trial - {1'b0, divisor});
            quo_in = {quo_ff[brsc_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[brsc_pkg::SS_W-1:0];
            quo_in = {quo_ff[brsc_pkg::DIV_W-2:0], 1'b0};
         end
      end
   end

   // Control state is cleared by reset; the datapath is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ sv/brsc_front.sv @@
// Front part: accepts a request, checks it and plans its sector commands.
// Depends on brsc_pkg and brsc_div.
module brsc_front #(
   parameter int SCRATCH_BYTES = 512
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_mode,
   input  logic [40:0]              req_offset,
   input  logic [31:0]              req_length,
   input  logic [12:0]              sec_bytes,
   input  logic [31:0]              sector_total,
   input  logic                     read_only,
   input  logic                     q_full,
   output logic                     q_push,
   output brsc_pkg::desc_type       q_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_CAP, S_CHECK, S_DIV, S_PLAN, S_MUL, S_PUSH
   } state_type;

   state_type          state_ff;
   logic               wr_ff;
   logic [40:0]        off_ff;
   logic [31:0]        len_ff;
   logic [44:0]        cap_ff;
   logic               div_go_ff;
   brsc_pkg::desc_type desc_ff;

   logic [brsc_pkg::DIV_W-1:0] end_byte;
   logic [44:0]                room;
   logic                       done_a, done_b;
   logic [brsc_pkg::DIV_W-1:0] q1, q2;
   logic [brsc_pkg::SS_W-1:0]  r1, r2;

   // Plan terms.
   logic                       head, head_only, ends_in_head, tail, run;
   logic [brsc_pkg::SS_W-1:0]  head_n, tail_bytes;
   logic [32:0]                f_ext, cnt_ext;
   logic [44:0]                run_bytes;

   assign end_byte = brsc_pkg::DIV_W'({1'b0, off_ff}) + brsc_pkg::DIV_W'(len_ff)
                     - brsc_pkg::DIV_W'(1);
   assign room     = cap_ff - 45'(off_ff);

   brsc_div u_div_first (
      .clock, .reset, .go(div_go_ff), .dividend(brsc_pkg::DIV_W'(off_ff)),
      .divisor(sec_bytes), .done(done_a), .quotient(q1), .remainder(r1)
   );

   brsc_div u_div_last (
      .clock, .reset, .go(div_go_ff), .dividend(end_byte),
      .divisor(sec_bytes), .done(done_b), .quotient(q2), .remainder(r2)
   );

   // Head, middle run and tail of the range. A request that starts unaligned
   // and ends in the same sector is covered by the head alone.
   always_comb begin
      head         = (r1 != '0);
      head_only    = (q1 == q2);
      ends_in_head = head && head_only;
      head_n       = head_only ? len_ff[brsc_pkg::SS_W-1:0] : sec_bytes - r1;
      f_ext        = (head && !head_only) ? {1'b0, q1[31:0]} + 33'd1 : {1'b0, q1[31:0]};
      tail_bytes   = r2 + brsc_pkg::SS_W'(1);
      tail         = !ends_in_head && (tail_bytes != sec_bytes);
      run          = !ends_in_head && ((f_ext + {32'd0, tail}) <= {1'b0, q2[31:0]});
      cnt_ext      = {1'b0, q2[31:0]} - f_ext + 33'd1 - {32'd0, tail};
      run_bytes    = 45'(desc_ff.run_cnt) * 45'(sec_bytes);
   end

   // Sequencer over check, divide, plan and hand-off.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         div_go_ff <= 1'b0;
      end else begin
         div_go_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  wr_ff    <= req_mode;
                  off_ff   <= req_offset;
                  len_ff   <= req_length;
                  state_ff <= S_CAP;
               end
            end
            S_CAP: begin
               cap_ff   <= 45'(sector_total) * 45'(sec_bytes);
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               desc_ff        <= '0;
               desc_ff.wr     <= wr_ff;
               desc_ff.status <= brsc_pkg::ST_OK;
               state_ff       <= S_PUSH;
               if (len_ff == 32'd0) begin
                  desc_ff.status <= brsc_pkg::ST_INVALID;
               end else if (wr_ff && read_only) begin
                  desc_ff.status <= brsc_pkg::ST_READ_ONLY;
               end else if (sec_bytes == 13'd0 ||
                            sec_bytes > 13'(SCRATCH_BYTES)) begin
                  desc_ff.status <= brsc_pkg::ST_INVALID;
               end else if (45'(off_ff) >= cap_ff || 45'(len_ff) > room) begin
                  desc_ff.status <= brsc_pkg::ST_INVALID;
               end else begin
                  div_go_ff <= 1'b1;
                  state_ff  <= S_DIV;
               end
            end
            S_DIV: begin
               if (done_a && done_b) begin
                  state_ff <= S_PLAN;
               end
            end
            S_PLAN: begin
               desc_ff.head       <= head;
               desc_ff.head_only  <= head_only;
               desc_ff.run        <= run;
               desc_ff.tail       <= tail;
               desc_ff.first      <= q1[31:0];
               desc_ff.lastsec    <= q2[31:0];
               desc_ff.skip       <= r1;
               desc_ff.head_n     <= head_n;
               desc_ff.tail_bytes <= tail_bytes;
               desc_ff.run_sec    <= f_ext[31:0];
               desc_ff.run_cnt    <= cnt_ext[31:0];
               desc_ff.run_boff   <= (head && !head_only) ? 32'(head_n) : 32'd0;
               state_ff           <= S_MUL;
            end
            S_MUL: begin
               desc_ff.tail_boff <= desc_ff.run ? desc_ff.run_boff + run_bytes[31:0]
                                                : desc_ff.run_boff;
               state_ff          <= S_PUSH;
            end
            S_PUSH: begin
               if (!q_full) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy   = (state_ff != S_IDLE);
   assign q_push = (state_ff == S_PUSH) && !q_full;
   assign q_data = desc_ff;

   // Both dividers are started together and finish together.
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      done_a == done_b) else $error("dividers out of step");

   // A division only completes while the sequencer waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      done_a |-> state_ff == S_DIV) else $error("divider done outside wait");

   // An item hand-off returns the front to idle.
   a_push_busy: assert property (@(posedge clock) disable iff (reset)
      q_push |=> !busy) else $error("front stayed busy after hand-off");

endmodule

@@ sv/brsc_fifo.sv @@
// Two-entry queue of request plans between the front and the back.
// Depends on brsc_pkg for the plan type.
module brsc_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  brsc_pkg::desc_type push_data,
   input  logic               pop,
   output brsc_pkg::desc_type pop_data,
   output logic               full,
   output logic               empty
);

   brsc_pkg::desc_type mem_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         count_ff;

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);

   // The fill count never passes the depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue count out of range");

   // The pointers differ exactly when the queue is partly filled.
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff != rd_ptr_ff) == (count_ff == 2'd1)) else $error("queue pointers off");

   // Popping an empty queue would be a control slip.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue underflow");

endmodule

@@ sv/brsc_back.sv @@
// Back part: walks one request plan and emits its sector commands in order.
// Depends on brsc_pkg.
module brsc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  brsc_pkg::desc_type q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   output logic [2:0]         rsp_action,
   output logic [31:0]        rsp_sector,
   output logic [31:0]        rsp_run_count,
   output logic [31:0]        rsp_buffer_offset,
   output logic [8:0]         rsp_scratch_offset,
   output logic [9:0]         rsp_copy_length,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   logic               active_ff;
   logic [1:0]         err_ff;
   logic [4:0]         mask_ff;
   brsc_pkg::desc_type desc_ff;
   logic [4:0]         mask_load;
   logic [4:0]         pick;

   logic               valid_ff;
   logic [2:0]         action_ff;
   logic [31:0]        sector_ff, count_ff, boff_ff;
   logic [8:0]         soff_ff;
   logic [9:0]         clen_ff;
   logic [1:0]         status_ff;
   logic               last_ff;

   // Commands present in a plan: head read, head write, run, tail read, tail write.
   always_comb begin
      mask_load[0] = q_data.head;
      mask_load[1] = q_data.head && q_data.wr;
      mask_load[2] = q_data.run;
      mask_load[3] = q_data.tail;
      mask_load[4] = q_data.tail && q_data.wr;
      pick = mask_ff & (~mask_ff + 5'd1);
   end

   assign q_pop = !active_ff && !q_empty;

   // Load a plan, then emit one command per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         if (q_pop) begin
            active_ff <= 1'b1;
            desc_ff   <= q_data;
            mask_ff   <= mask_load;
            if (q_data.status != brsc_pkg::ST_OK) begin
               err_ff <= q_data.status;
            end else if (mask_load == 5'd0) begin
               err_ff <= brsc_pkg::ST_INVALID;
            end else begin
               err_ff <= brsc_pkg::ST_OK;
            end
         end else if (active_ff) begin
            valid_ff  <= 1'b1;
            sector_ff <= 32'd0;
            count_ff  <= 32'd1;
            boff_ff   <= 32'd0;
            soff_ff   <= 9'd0;
            clen_ff   <= 10'd0;
            status_ff <= brsc_pkg::ST_OK;
            mask_ff   <= mask_ff & ~pick;
            last_ff   <= (mask_ff & ~pick) == 5'd0;
            active_ff <= (mask_ff & ~pick) != 5'd0;
            if (err_ff != brsc_pkg::ST_OK) begin
               action_ff <= brsc_pkg::ACT_STATUS;
               count_ff  <= 32'd0;
               status_ff <= err_ff;
               last_ff   <= 1'b1;
               active_ff <= 1'b0;
            end else begin
               priority if (pick[0]) begin
                  action_ff <= brsc_pkg::ACT_RD_SCRATCH;
                  sector_ff <= desc_ff.first;
                  if (!desc_ff.wr) begin
                     soff_ff <= desc_ff.skip[8:0];
                     clen_ff <= desc_ff.head_n[9:0];
                  end
               end else if (pick[1]) begin
                  action_ff <= brsc_pkg::ACT_WR_SCRATCH;
                  sector_ff <= desc_ff.first;
                  soff_ff   <= desc_ff.skip[8:0];
                  clen_ff   <= desc_ff.head_n[9:0];
               end else if (pick[2]) begin
                  action_ff <= desc_ff.wr ? brsc_pkg::ACT_WR_RUN : brsc_pkg::ACT_RD_RUN;
                  sector_ff <= desc_ff.run_sec;
                  count_ff  <= desc_ff.run_cnt;
                  boff_ff   <= desc_ff.run_boff;
               end else if (pick[3]) begin
                  action_ff <= brsc_pkg::ACT_RD_SCRATCH;
                  sector_ff <= desc_ff.lastsec;
                  if (!desc_ff.wr) begin
                     boff_ff <= desc_ff.tail_boff;
                     clen_ff <= desc_ff.tail_bytes[9:0];
                  end
               end else begin
                  action_ff <= brsc_pkg::ACT_WR_SCRATCH;
                  sector_ff <= desc_ff.lastsec;
                  boff_ff   <= desc_ff.tail_boff;
                  clen_ff   <= desc_ff.tail_bytes[9:0];
               end
            end
         end
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_action         = action_ff;
   assign rsp_sector         = sector_ff;
   assign rsp_run_count      = count_ff;
   assign rsp_buffer_offset  = boff_ff;
   assign rsp_scratch_offset = soff_ff;
   assign rsp_copy_length    = clen_ff;
   assign rsp_status         = status_ff;
   assign rsp_last           = last_ff;

   // A status-only result always closes its request.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == brsc_pkg::ACT_STATUS |-> rsp_last)
      else $error("status result not last");

   // The final command of a request leaves the walker idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !active_ff) else $error("walker active after last");

   // Scratch commands cover exactly one sector.
   a_scratch_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == brsc_pkg::ACT_RD_SCRATCH ||
                    rsp_action == brsc_pkg::ACT_WR_SCRATCH) |-> rsp_run_count == 32'd1)
      else $error("scratch command count not one");

endmodule

@@ sv/byte_range_to_sector_commands_top.sv @@
// Top level of the byte range to sector command splitter.
// Depends on brsc_pkg, brsc_front, brsc_fifo and brsc_back.
//
// Usage:
//   A request (req_mode, req_offset, req_length) is taken at a rising edge
//   with start high and busy low. The block answers with one to five
//   sector commands on the rsp_ ports, each shown for one cycle with
//   rsp_valid high; rsp_last marks the final command of the request. A
//   rejected request gives a single status-only command.
//   Registers are written through csr_we, csr_index and csr_wdata; the user
//   must write them only while the block is idle, which the block does not
//   enforce: index 0 sector size, 1 sector total, 2 read-only.
//   A valid request keeps the front busy after it is taken through the
//   capacity and validity checks, the start of the two 42-step dividers
//   that run side by side, the division steps, seeing them finish, planning
//   and the hand-off, which waits while the queue is full. A rejected
//   request keeps it busy through the checks and the hand-off only. The
//   back, once idle, loads the plan from the queue and then emits one
//   command per cycle. The front takes a new request only after handing off
//   the last; the two-entry queue lets it work while the back emits.
//   Reset clears all control state and loads the register reset values.
//   The receiver cannot stall; results must be taken as shown.
module byte_range_to_sector_commands_top #(
   parameter int SCRATCH_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [40:0] req_offset,
   input  logic [31:0] req_length,
   output logic        rsp_valid,
   output logic [2:0]  rsp_action,
   output logic [31:0] rsp_sector,
   output logic [31:0] rsp_run_count,
   output logic [31:0] rsp_buffer_offset,
   output logic [8:0]  rsp_scratch_offset,
   output logic [9:0]  rsp_copy_length,
   output logic [1:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [12:0]        sec_bytes_ff;
   logic [31:0]        sector_total_ff;
   logic               read_only_ff;
   logic               q_full, q_empty, q_push, q_pop;
   brsc_pkg::desc_type q_in, q_out;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sec_bytes_ff    <= 13'd512;
         sector_total_ff <= 32'd0;
         read_only_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            brsc_pkg::CSR_SECTOR_SIZE:  sec_bytes_ff    <= csr_wdata[12:0];
            brsc_pkg::CSR_SECTOR_TOTAL: sector_total_ff <= csr_wdata;
            brsc_pkg::CSR_READ_ONLY:    read_only_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   brsc_front #(.SCRATCH_BYTES(SCRATCH_BYTES)) u_front (
      .clock, .reset, .start, .busy, .req_mode, .req_offset, .req_length,
      .sec_bytes(sec_bytes_ff), .sector_total(sector_total_ff),
      .read_only(read_only_ff), .q_full, .q_push, .q_data(q_in)
   );

   brsc_fifo u_fifo (
      .clock, .reset, .push(q_push), .push_data(q_in), .pop(q_pop),
      .pop_data(q_out), .full(q_full), .empty(q_empty)
   );

   brsc_back u_back (
      .clock, .reset, .q_empty, .q_data(q_out), .q_pop, .rsp_valid, .rsp_action,
      .rsp_sector, .rsp_run_count, .rsp_buffer_offset, .rsp_scratch_offset,
      .rsp_copy_length, .rsp_status, .rsp_last
   );

endmodule
